// ===== rtl/core/dhcp_rp_pkg.sv =====
// Package for the DHCP reply parser: constants, codes, types and the option slot lookup.
`default_nettype none

package dhcp_rp_pkg;

  localparam int unsigned MaxLenDefault = 600;
  localparam int unsigned CountW        = 10;
  localparam int unsigned ResultW       = 144;

  localparam logic [CountW-1:0] CountMax  = 10'd1023;
  localparam logic [CountW-1:0] MinLast   = 10'd239;
  localparam logic [CountW-1:0] OptStart  = 10'd240;

  localparam logic [7:0] BootReply = 8'd2;
  localparam logic [7:0] OptPad    = 8'd0;
  localparam logic [7:0] OptEnd    = 8'd255;
  localparam logic [7:0] OptMsg    = 8'd53;
  localparam logic [7:0] OptServer = 8'd54;
  localparam logic [7:0] OptRouter = 8'd3;
  localparam logic [7:0] OptDns    = 8'd6;

  typedef enum logic [1:0] {
    SLOT_MSG    = 2'd0,
    SLOT_SERVER = 2'd1,
    SLOT_ROUTER = 2'd2,
    SLOT_DNS    = 2'd3
  } slot_e;

  typedef enum logic [0:0] {
    REG_XID    = 1'b0,
    REG_ENABLE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_LONG      = 3'd3,
    ST_NOT_REPLY = 3'd4,
    ST_XID_MISM  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [7:0]        op;
    logic [31:0]       xid;
    phase_e            phase;
    logic [7:0]        code;
    logic [7:0]        len;
    logic [7:0]        rem;
    logic [31:0]       value;
    logic [31:0]       yiaddr;
    logic [3:0][31:0]  capt;
    logic [3:0]        found;
    logic [3:0]        seen;
  } pkt_t;

  typedef struct packed {
    logic        dns_valid;
    logic [31:0] dns_addr;
    logic        router_valid;
    logic [31:0] router_addr;
    logic        srv_addr_valid;
    logic [31:0] srv_addr;
    logic        dhcp_kind_valid;
    logic [7:0]  dhcp_kind;
    logic [31:0] your_ip;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic  hit;
    slot_e slot;
  } slot_t;

  function automatic slot_t slot_of(input logic [7:0] code);
    slot_t s;
    s.hit  = 1'b1;
    s.slot = SLOT_MSG;
    case (code)
      OptMsg:    s.slot = SLOT_MSG;
      OptServer: s.slot = SLOT_SERVER;
      OptRouter: s.slot = SLOT_ROUTER;
      OptDns:    s.slot = SLOT_DNS;
      default:   s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dhcp_reply_parser.sv =====
// DHCP reply parser: one byte per cycle in, one summary request out per packet.
//
// Input stream s_axis_*: tdata carries one UDP payload byte, tlast marks the
// final byte of the packet. A byte is taken whenever tvalid and tready are high.
// Output stream m_axis_*: one request per packet, carrying the status code,
// yiaddr and the message-type, server-id, router and DNS options.
// Config channel cfg_*: index 0 writes the expected transaction id, index 1 the
// enable bit. It is always ready; write it only while no packet is in flight.
// Throughput: one byte per cycle while tready is high. The option walk,
// header capture and status decision are one short combinational step from
// the packet state registers. The result is registered from the last byte.
// Stalls: a result waits in the output register; a second result finishing
// behind it goes into a skid register and only then is tready dropped, so a
// stalled receiver does not stall the input until two results are pending.
// Reset: all packet state clears, expected id is zero and the block is
// disabled, so every packet is reported as disabled until enabled.
`default_nettype none

module dhcp_reply_parser
  import dhcp_rp_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  wire logic               s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [2:0] status, [34:3] your_ip, [42:35] dhcp_kind, [43] dhcp_kind_valid,
  // [75:44] srv_addr, [76] srv_addr_valid, [108:77] router_addr,
  // [109] router_valid, [141:110] dns_addr, [142] dns_valid, [143] zero
  output logic [ResultW-1:0]      m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam logic [CountW-1:0] MaxLenC = CountW'(MAX_LEN);

  logic [31:0] xid_cfg_q;
  logic        enable_q;

  pkt_t    pkt_q, pkt_d, nxt;
  result_t res;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    in_acc, res_new, done_now;
  slot_t   sl;
  logic    ok;
  logic [7:0] consumed;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign res_new       = in_acc && s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_cfg_q <= '0;
      enable_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_XID:    xid_cfg_q <= cfg_data_i;
        REG_ENABLE: enable_q  <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // next packet state before the end-of-packet clear
  always_comb begin
    nxt      = pkt_q;
    done_now = 1'b0;
    consumed = pkt_q.len - pkt_q.rem;
    if (pkt_q.count == '0) nxt.op = s_axis_tdata;
    if (pkt_q.count >= CountW'(4) && pkt_q.count <= CountW'(7)) begin
      nxt.xid = {pkt_q.xid[23:0], s_axis_tdata};
    end
    if (pkt_q.count >= CountW'(16) && pkt_q.count <= CountW'(19)) begin
      nxt.yiaddr = {pkt_q.yiaddr[23:0], s_axis_tdata};
    end
    if (pkt_q.count >= OptStart) begin
      case (pkt_q.phase)
        PH_CODE: begin
          if (s_axis_tdata == OptEnd) begin
            nxt.phase = PH_DONE;
          end else if (s_axis_tdata != OptPad) begin
            nxt.code  = s_axis_tdata;
            nxt.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          nxt.len   = s_axis_tdata;
          nxt.rem   = s_axis_tdata;
          nxt.value = '0;
          if (s_axis_tdata == '0) begin
            done_now  = 1'b1;
            nxt.phase = PH_CODE;
          end else begin
            nxt.phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (consumed < 8'd4) nxt.value = {pkt_q.value[23:0], s_axis_tdata};
          nxt.rem = pkt_q.rem - 8'd1;
          if (nxt.rem == '0) begin
            done_now  = 1'b1;
            nxt.phase = PH_CODE;
          end
        end
        PH_DONE: ;
        default: nxt.phase = PH_DONE;
      endcase
    end
    if (pkt_q.count != CountMax) nxt.count = pkt_q.count + CountW'(1);

    sl = slot_of(nxt.code);
    ok = 1'b0;
    case (sl.slot)
      SLOT_MSG:    ok = (nxt.len == 8'd1);
      SLOT_SERVER: ok = (nxt.len == 8'd4);
      default:     ok = (nxt.len >= 8'd4);
    endcase
    if (done_now && sl.hit && !pkt_q.seen[sl.slot]) begin
      nxt.seen[sl.slot] = 1'b1;
      if (ok) begin
        nxt.found[sl.slot] = 1'b1;
        nxt.capt[sl.slot]  = (sl.slot == SLOT_MSG) ? {24'd0, nxt.value[7:0]} : nxt.value;
      end
    end
  end

  always_comb begin
    pkt_d = pkt_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        pkt_d       = '0;
        pkt_d.phase = PH_CODE;
      end else begin
        pkt_d = nxt;
      end
    end
  end

  always_comb begin
    res = '0;
    if (!enable_q)                      res.status = ST_DISABLED;
    else if (pkt_q.count < MinLast)     res.status = ST_SHORT;
    else if (pkt_q.count >= MaxLenC)    res.status = ST_LONG;
    else if (nxt.op != BootReply)       res.status = ST_NOT_REPLY;
    else if (nxt.xid != xid_cfg_q)      res.status = ST_XID_MISM;
    else                                res.status = ST_ACCEPTED;
    if (res.status == ST_ACCEPTED) begin
      res.your_ip         = nxt.yiaddr;
      res.dhcp_kind_valid = nxt.found[SLOT_MSG];
      res.dhcp_kind       = nxt.found[SLOT_MSG] ? nxt.capt[SLOT_MSG][7:0] : 8'd0;
      res.srv_addr_valid  = nxt.found[SLOT_SERVER];
      res.srv_addr        = nxt.found[SLOT_SERVER] ? nxt.capt[SLOT_SERVER] : 32'd0;
      res.router_valid    = nxt.found[SLOT_ROUTER];
      res.router_addr     = nxt.found[SLOT_ROUTER] ? nxt.capt[SLOT_ROUTER] : 32'd0;
      res.dns_valid       = nxt.found[SLOT_DNS];
      res.dns_addr        = nxt.found[SLOT_DNS] ? nxt.capt[SLOT_DNS] : 32'd0;
    end
  end

  // output register with one skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = res_new;
      end
    end else if (res_new) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q        <= '{phase: PH_CODE, default: '0};
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pkt_q        <= pkt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(pkt_q.phase))
    else $error("option phase not one-hot");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_new |=> (pkt_q.count == '0 && pkt_q.found == '0 && pkt_q.seen == '0))
    else $error("packet state not cleared after final byte");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_ACCEPTED) |->
      (out_q.your_ip == '0 && !out_q.dhcp_kind_valid && !out_q.srv_addr_valid &&
       !out_q.router_valid && !out_q.dns_valid))
    else $error("rejected packet carries data");

  a_found_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_q.found & ~pkt_q.seen) == '0)
    else $error("option found without first occurrence mark");

endmodule

`default_nettype wire
